// ===== design/ppsb_pkg.sv =====
package ppsb_pkg;

  // Fixed port widths of the block
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned PROD_W  = 36;
  localparam int unsigned POS_W   = 5;

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_RUN
  } ppsb_state_e;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic load;  // write the selected cell with the incoming pair
    logic clr;   // zero the product and partial-sum registers
    logic adv;   // advance the chain by one step
  } ppsb_ctrl_t;

endpackage

// ===== design/ppsb_cell.sv =====
module ppsb_cell
  import ppsb_pkg::*;
#(
  parameter int unsigned COEFF_BITS = 16
) (
  input  logic                          clk_i,
  input  ppsb_ctrl_t                    ctrl_i,
  input  logic                          sel_i,
  input  logic                          active_i,
  input  logic signed [COEFF_BITS-1:0]  a_i,
  input  logic signed [COEFF_BITS-1:0]  b_i,
  input  logic signed [COEFF_BITS-1:0]  x_i,
  input  logic signed [COEFF_BITS-1:0]  b_nbr_i,
  output logic signed [COEFF_BITS-1:0]  b_o,
  input  logic signed [PROD_W-1:0]      sum_nbr_i,
  output logic signed [PROD_W-1:0]      sum_o
);

  localparam int unsigned MUL_W = 2 * COEFF_BITS;

  logic signed [COEFF_BITS-1:0] a_q;
  logic signed [COEFF_BITS-1:0] b_q;
  logic signed [MUL_W-1:0]      mul;
  logic signed [PROD_W-1:0]     mul_ext;
  logic signed [PROD_W-1:0]     prod_d, prod_q;
  logic signed [PROD_W-1:0]     sum_d, sum_q;

  assign mul = a_q * x_i;

  // Keep the product modulo 2^PROD_W
  if (MUL_W >= PROD_W) begin : g_trunc
    assign mul_ext = mul[PROD_W-1:0];
  end else begin : g_sext
    assign mul_ext = {{(PROD_W - MUL_W){mul[MUL_W-1]}}, mul};
  end

  // Drop the contribution of cells past the loaded length
  assign prod_d = active_i ? mul_ext : '0;
  assign sum_d  = prod_q + sum_nbr_i;

  assign b_o   = active_i ? b_q : '0;
  assign sum_o = sum_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && sel_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (ctrl_i.adv) begin
      b_q <= b_nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      prod_q <= '0;
      sum_q  <= '0;
    end else if (ctrl_i.adv) begin
      prod_q <= prod_d;
      sum_q  <= sum_d;
    end
  end

endmodule

// ===== design/polynomial_product_schoolbook_top.sv =====
// Output: the first product coefficient is registered at chain step 2 after the closing transaction;
// the remaining 2n-2 follow one per cycle while the output is not stalled.
// Run: a set of n input transactions takes n loads plus 2n+1 chain steps, during which
// input is stalled; the chain emits one coefficient per step from step 2 onward.
// Reset: clears the sequencer, load count and output valid; the coefficient stores
// hold no defined value until loaded.
module polynomial_product_schoolbook_top
  import ppsb_pkg::*;
#(
  parameter int unsigned MAX_TERMS  = 16,
  parameter int unsigned COEFF_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [FIELD_W-1:0] a_coeff_i,
  input  logic signed [FIELD_W-1:0] b_coeff_i,
  input  logic                      last_term_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [PROD_W-1:0]  product_coeff_o,
  output logic        [POS_W-1:0]   position_o,
  output logic                      final_coeff_o
);

  // CW holds a term count up to MAX_TERMS, SW a step count up to 2*MAX_TERMS
  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam int unsigned SW = $clog2(2 * MAX_TERMS + 1);

  ppsb_state_e state_q, state_d;
  ppsb_ctrl_t  ctrl;

  logic [CW-1:0] load_cnt_q, load_cnt_d;
  logic [CW-1:0] n_q, n_d;
  logic [SW-1:0] len_q, len_d;
  logic [SW-1:0] step_q, step_d;

  logic in_acc;
  logic close;
  logic adv;
  logic run_done;
  logic emit;

  logic signed [COEFF_BITS-1:0] a_val, b_val;

  // Neighbor links; the entry past the top cell feeds zeros into the chain
  logic signed [COEFF_BITS-1:0] b_link   [MAX_TERMS+1];
  logic signed [PROD_W-1:0]     sum_link [MAX_TERMS+1];

  logic [SW-1:0]        pos_diff;
  logic [SW+POS_W-1:0]  pos_wide;

  logic                     out_valid_q, out_valid_d;
  logic signed [PROD_W-1:0] out_coeff_q;
  logic [POS_W-1:0]         out_pos_q;
  logic                     out_final_q;

  //--------------------------------------------------------------------------
  // Coefficient decode: keep the low COEFF_BITS of each field as a signed
  // value; a wider coefficient takes the field zero-extended.
  //--------------------------------------------------------------------------
  if (COEFF_BITS <= FIELD_W) begin : g_dec_narrow
    assign a_val = a_coeff_i[COEFF_BITS-1:0];
    assign b_val = b_coeff_i[COEFF_BITS-1:0];
  end else begin : g_dec_wide
    assign a_val = {{(COEFF_BITS - FIELD_W){1'b0}}, a_coeff_i};
    assign b_val = {{(COEFF_BITS - FIELD_W){1'b0}}, b_coeff_i};
  end

  //--------------------------------------------------------------------------
  // Sequencer
  //--------------------------------------------------------------------------
  assign in_acc   = in_valid_i && !in_stall_o;
  // A transaction that fills the last free cell closes loading by itself
  assign close    = last_term_i || (load_cnt_q == CW'(MAX_TERMS - 1));
  assign run_done = (step_q == len_q + SW'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && close) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (adv && run_done) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    adv        = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
      end
      ST_RUN: begin
        // Step the chain only when the output register can take a result
        adv = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
    ctrl.load = in_acc;
    ctrl.clr  = in_acc && close;
    ctrl.adv  = adv;
  end

  always_comb begin
    load_cnt_d = load_cnt_q;
    n_d        = n_q;
    len_d      = len_q;
    step_d     = step_q;
    if (in_acc) begin
      if (close) begin
        load_cnt_d = '0;
        n_d        = load_cnt_q + CW'(1);
        len_d      = SW'({n_d, 1'b0}) - SW'(1);
        step_d     = '0;
      end else begin
        load_cnt_d = load_cnt_q + CW'(1);
      end
    end else if (adv) begin
      step_d = step_q + SW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      n_q        <= '0;
      len_q      <= '0;
      step_q     <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      n_q        <= n_d;
      len_q      <= len_d;
      step_q     <= step_d;
    end
  end

  //--------------------------------------------------------------------------
  // Cell chain (transposed convolution). Cell i keeps a[i]; b shifts toward
  // cell 0, which broadcasts the current b term to all cells. Partial sums
  // move from the top cell down, and cell 0's sum is the next coefficient.
  //--------------------------------------------------------------------------
  assign b_link[MAX_TERMS]   = '0;
  assign sum_link[MAX_TERMS] = '0;

  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    logic sel;
    logic active;

    assign sel    = (load_cnt_q == CW'(i));
    assign active = (CW'(i) < n_q);

    ppsb_cell #(
      .COEFF_BITS (COEFF_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .sel_i     (sel),
      .active_i  (active),
      .a_i       (a_val),
      .b_i       (b_val),
      .x_i       (b_link[0]),
      .b_nbr_i   (b_link[i+1]),
      .b_o       (b_link[i]),
      .sum_nbr_i (sum_link[i+1]),
      .sum_o     (sum_link[i])
    );
  end

  //--------------------------------------------------------------------------
  // Output register. After step c the chain's head holds coefficient c-2,
  // so emit from step 2 through step 2n.
  //--------------------------------------------------------------------------
  assign emit     = adv && (step_q >= SW'(2));
  assign pos_diff = step_q - SW'(2);
  assign pos_wide = {{POS_W{1'b0}}, pos_diff};

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_coeff_q <= sum_link[0];
      out_pos_q   <= POS_W'(pos_wide);
      out_final_q <= run_done;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign product_coeff_o = out_coeff_q;
  assign position_o      = out_pos_q;
  assign final_coeff_o   = out_final_q;

  //--------------------------------------------------------------------------
  // Assertions
  //--------------------------------------------------------------------------
  a_close_starts_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && close) |=> (state_q == ST_RUN && step_q == '0))
    else $error("closing transaction did not start a product run");

  a_step_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> ((SW + 1)'(step_q) <= (SW + 1)'(len_q) + (SW + 1)'(1)))
    else $error("chain step count ran past the end of the product");

  a_load_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_cnt_q < CW'(MAX_TERMS))
    else $error("load count reached the store depth");

  a_emit_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (state_q == ST_RUN && n_q != '0))
    else $error("result emitted outside a product run");

endmodule
